[design/plb_pkg.sv]
// shared types and codes for the port link bring-up sequencer
package plb_pkg;

    // event kinds carried in func
    typedef enum logic [1:0] {
        FUNC_ENABLE  = 2'd0,
        FUNC_DISABLE = 2'd1,
        FUNC_RETRY   = 2'd2
    } plb_func_t;

    // sequencer states, also the link_state result code
    typedef enum logic [2:0] {
        LS_DISABLED    = 3'd0,
        LS_ENABLED     = 3'd1,
        LS_SERDES_CFG  = 3'd2,
        LS_WAIT_READY  = 3'd3,
        LS_MAC_CFG     = 3'd4,
        LS_SIG_DETECT  = 3'd5,
        LS_WAIT_FAULTS = 3'd6,
        LS_UP          = 3'd7
    } plb_link_state_t;

    // retry timer request codes
    typedef enum logic [1:0] {
        TMR_NONE   = 2'd0,
        TMR_START  = 2'd1,
        TMR_CANCEL = 2'd2
    } plb_timer_t;

    localparam int LANE_BITS = 4;
    localparam int LANE_CNT_W = 3;

    // input item
    typedef struct packed {
        plb_func_t              func;
        logic [LANE_BITS-1:0]   serdes_ready_lanes;
        logic [LANE_BITS-1:0]   signal_detect_lanes;
        logic                   mac_fault;
    } plb_in_t;

    // result item
    typedef struct packed {
        plb_link_state_t link_state;
        logic            oper_up;
        plb_timer_t      retry_timer;
        logic            serdes_cfg_strobe;
        logic            serdes_txrx_enable;
        logic            serdes_drv_en;
        logic            mac_cfg_strobe;
        logic            mac_run_en;
        logic            mac_sw_rst;
        logic            mac_cnt_rst;
        logic            mac_irq_en;
        logic            mac_intr_clear_strobe;
    } plb_out_t;

    // MAC and SerDes control levels
    typedef struct packed {
        logic txrx_en;
        logic serdes_out_en;
        logic mac_en;
        logic soft_rst;
        logic stats_rst;
        logic intr_en;
    } plb_levels_t;

    // sequencer state kept between items
    typedef struct packed {
        plb_link_state_t seq;
        logic            admin;
        logic            oper;
        plb_levels_t     levels;
    } plb_state_t;

endpackage

[design/plb_seq.sv]
// one-event fall-through of the bring-up sequence: next state and result item
module plb_seq #(
    parameter int MAX_LANES = 4
) (
    input  plb_pkg::plb_in_t                  item,
    input  logic [plb_pkg::LANE_CNT_W-1:0]    lane_count,
    input  plb_pkg::plb_state_t               state,
    output plb_pkg::plb_state_t               state_next,
    output plb_pkg::plb_out_t                 result
);

    localparam int EXT_W = MAX_LANES + plb_pkg::LANE_BITS;

    // true when at least one lane is active and every active lane reports its status bit
    function automatic logic lanes_ok(
        input logic [plb_pkg::LANE_BITS-1:0]  bits,
        input logic [plb_pkg::LANE_CNT_W-1:0] cnt
    );
        logic [EXT_W-1:0] ext;
        logic [3:0]       n_eff;
        logic             ok;
        ext = {{MAX_LANES{1'b0}}, bits};
        if ({1'b0, cnt} > 4'(MAX_LANES))
            n_eff = 4'(MAX_LANES);
        else
            n_eff = {1'b0, cnt};
        ok = (n_eff != 4'd0);
        for (int i = 0; i < MAX_LANES; i++)
        begin
            if (4'(i) < n_eff)
                ok = ok & ext[i];
        end
        return ok;
    endfunction

    logic                     run;
    plb_pkg::plb_link_state_t start;
    logic                     rdy_ok;
    logic                     sig_ok;
    logic                     r_dis;
    logic                     r1, r2, r3, r4, r5, r6, r7;
    logic                     wait_fail;

    // event decode and reach chain through the steps
    always_comb
    begin
        run   = 1'b0;
        start = state.seq;
        case (item.func)
            plb_pkg::FUNC_ENABLE:
            begin
                if (!state.admin)
                begin
                    run   = 1'b1;
                    start = plb_pkg::LS_ENABLED;
                end
            end
            plb_pkg::FUNC_DISABLE:
            begin
                if (state.admin)
                begin
                    run   = 1'b1;
                    start = plb_pkg::LS_DISABLED;
                end
            end
            plb_pkg::FUNC_RETRY:
            begin
                run = 1'b1;
            end
            default:
            begin
                run = 1'b0;
            end
        endcase

        rdy_ok = lanes_ok(item.serdes_ready_lanes, lane_count);
        sig_ok = lanes_ok(item.signal_detect_lanes, lane_count);

        r_dis = run && (start == plb_pkg::LS_DISABLED);
        r1 = run && (start == plb_pkg::LS_ENABLED);
        r2 = (run && (start == plb_pkg::LS_SERDES_CFG)) || r1;
        r3 = (run && (start == plb_pkg::LS_WAIT_READY)) || r2;
        r4 = (run && (start == plb_pkg::LS_MAC_CFG)) || (r3 && rdy_ok);
        r5 = (run && (start == plb_pkg::LS_SIG_DETECT)) || r4;
        r6 = (run && (start == plb_pkg::LS_WAIT_FAULTS)) || (r5 && sig_ok);
        r7 = (run && (start == plb_pkg::LS_UP)) || (r6 && !item.mac_fault);

        wait_fail = (r3 && !r4) || (r5 && !r6) || (r6 && !r7);
    end

    // next state
    always_comb
    begin
        state_next = state;

        if (item.func == plb_pkg::FUNC_ENABLE)
            state_next.admin = 1'b1;
        else if (item.func == plb_pkg::FUNC_DISABLE)
            state_next.admin = 1'b0;

        if (r_dis)
        begin
            state_next.seq                  = plb_pkg::LS_DISABLED;
            state_next.oper                 = 1'b0;
            state_next.levels.intr_en       = 1'b0;
            state_next.levels.serdes_out_en = 1'b0;
            state_next.levels.soft_rst      = 1'b1;
            state_next.levels.mac_en        = 1'b0;
            state_next.levels.stats_rst     = 1'b1;
        end
        else if (run)
        begin
            if (r2)
                state_next.levels.txrx_en = 1'b1;
            if (r4)
            begin
                state_next.levels.stats_rst     = 1'b0;
                state_next.levels.mac_en        = 1'b1;
                state_next.levels.soft_rst      = 1'b0;
                state_next.levels.serdes_out_en = 1'b1;
            end
            if (r7)
            begin
                state_next.levels.intr_en = 1'b1;
                state_next.oper           = 1'b1;
                state_next.seq            = plb_pkg::LS_UP;
            end
            else if (r6)
                state_next.seq = plb_pkg::LS_WAIT_FAULTS;
            else if (r5)
                state_next.seq = plb_pkg::LS_SIG_DETECT;
            else if (r3)
                state_next.seq = plb_pkg::LS_WAIT_READY;
        end
    end

    // result item
    always_comb
    begin
        result.link_state            = state_next.seq;
        result.oper_up               = state_next.oper;
        result.serdes_cfg_strobe     = r2;
        result.serdes_txrx_enable    = state_next.levels.txrx_en;
        result.serdes_drv_en         = state_next.levels.serdes_out_en;
        result.mac_cfg_strobe        = r4;
        result.mac_run_en            = state_next.levels.mac_en;
        result.mac_sw_rst            = state_next.levels.soft_rst;
        result.mac_cnt_rst           = state_next.levels.stats_rst;
        result.mac_irq_en            = state_next.levels.intr_en;
        result.mac_intr_clear_strobe = r_dis;
        if (r_dis)
            result.retry_timer = plb_pkg::TMR_CANCEL;
        else if (wait_fail)
            result.retry_timer = plb_pkg::TMR_START;
        else
            result.retry_timer = plb_pkg::TMR_NONE;
    end

endmodule

[design/port_link_bringup_fsm_core.sv]
// link bring-up sequencer for one multi-lane port: item registers and state
// the item waits in the input item register; its result is registered into the output item register
// throughput: one item per cycle while the output is not stalled; the whole step sequence resolves in the
// single combinational pass between the input and result registers
// reset: state disabled, admin and oper down, MAC and stats in reset,
// other levels off, lane_count 1, both item registers empty
module port_link_bringup_fsm_core #(
    parameter int MAX_LANES = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  plb_pkg::plb_in_t                   in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output plb_pkg::plb_out_t                  out_item,
    input  logic                               cfg_we,
    input  logic [plb_pkg::LANE_CNT_W-1:0]     cfg_wdata
);

    logic                               in_hold_reg;
    logic                               in_hold_next;
    plb_pkg::plb_in_t                   in_item_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    plb_pkg::plb_out_t                  out_item_reg;
    logic [plb_pkg::LANE_CNT_W-1:0]     lane_count_reg;
    plb_pkg::plb_state_t                state_reg;
    plb_pkg::plb_state_t                state_next;
    plb_pkg::plb_out_t                  result;
    logic                               advance;
    logic                               in_take;
    logic                               fire;

    // handshake control
    assign advance        = !out_valid_reg || !out_stall;
    assign in_stall       = in_hold_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign fire           = in_hold_reg && advance;
    assign in_hold_next   = in_take || (in_hold_reg && !advance);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    // step logic
    plb_seq #(
        .MAX_LANES (MAX_LANES)
    ) u_seq (
        .item       (in_item_reg),
        .lane_count (lane_count_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_hold_reg                    <= 1'b0;
            out_valid_reg                  <= 1'b0;
            lane_count_reg                 <= plb_pkg::LANE_CNT_W'(1);
            state_reg.seq                  <= plb_pkg::LS_DISABLED;
            state_reg.admin                <= 1'b0;
            state_reg.oper                 <= 1'b0;
            state_reg.levels.txrx_en       <= 1'b0;
            state_reg.levels.serdes_out_en <= 1'b0;
            state_reg.levels.mac_en        <= 1'b0;
            state_reg.levels.soft_rst      <= 1'b1;
            state_reg.levels.stats_rst     <= 1'b1;
            state_reg.levels.intr_en       <= 1'b0;
        end
        else
        begin
            in_hold_reg   <= in_hold_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                lane_count_reg <= cfg_wdata;
            if (fire)
                state_reg <= state_next;
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_item;
        if (fire)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[design/plb_checker.sv]
// port-level checks for the link bring-up sequencer, bound to the top level
module plb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input plb_pkg::plb_out_t              out_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    // operational up only in the up state
    a_oper_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.oper_up |-> out_item.link_state == plb_pkg::LS_UP)
        else $error("oper up outside the up state");

    // MAC config leaves the MAC running, MAC and counters out of reset and the SerDes driver on
    a_mac_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.mac_cfg_strobe |->
            out_item.mac_run_en && !out_item.mac_sw_rst &&
            !out_item.mac_cnt_rst && out_item.serdes_drv_en)
        else $error("mac config without mac levels");

    // timer cancel only with a full teardown
    a_cancel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.retry_timer == plb_pkg::TMR_CANCEL) |->
            (out_item.link_state == plb_pkg::LS_DISABLED) && !out_item.oper_up &&
            out_item.mac_intr_clear_strobe && out_item.mac_sw_rst)
        else $error("timer cancel without teardown");

endmodule

bind port_link_bringup_fsm_core plb_checker u_plb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
